FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is high.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while reset is high.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/dvdn_pkg.sv
// Types, constants and tables shared by the date check and day number block.
`default_nettype none

package dvdn_pkg;

   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int FIELD_W   = 23;
   localparam int NUM_W     = 24;
   localparam int DIFF_W    = NUM_W + 1;
   localparam int PB_W      = 11;
   localparam int MTERM_W   = 9;
   localparam int Q_W       = 8;
   localparam int PROD_W    = 23;
   localparam int CSR_IDX_W = 4;

   localparam int RECIP_100     = 1311;
   localparam int RECIP_SHIFT   = 15;
   localparam int DAYS_PER_YEAR = 365;
   localparam int DAY_OFFSET    = 306;
   localparam int MONTHS        = 12;
   localparam int MARCH         = 3;
   localparam int FEBRUARY      = 2;
   localparam int CENTURY       = 100;

   localparam int RESET_YEAR_FLOOR   = 1;
   localparam int RESET_CURRENT_YEAR = 2023;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_YEAR_BAD  = 2'd1,
      STATUS_MONTH_BAD = 2'd2,
      STATUS_DAY_BAD   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ORDER_BEFORE = 2'd0,
      ORDER_EQUAL  = 2'd1,
      ORDER_AFTER  = 2'd2
   } order_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_YEAR_FLOOR   = 4'd0,
      CSR_CURRENT_YEAR = 4'd1
   } csr_reg_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      status_type              status;
      logic signed [NUM_W-1:0] days;
   } date_result_type;

   // Days before the shifted month, (153 * tm - 457) / 5 for tm from 3 to 15.
   function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] tm);
      logic [MTERM_W-1:0] v;
      case (tm)
         4'd4:    v = 9'd31;
         4'd5:    v = 9'd61;
         4'd6:    v = 9'd92;
         4'd7:    v = 9'd122;
         4'd8:    v = 9'd153;
         4'd9:    v = 9'd184;
         4'd10:   v = 9'd214;
         4'd11:   v = 9'd245;
         4'd12:   v = 9'd275;
         4'd13:   v = 9'd306;
         4'd14:   v = 9'd337;
         4'd15:   v = 9'd367;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // Length of a month in a common year; months outside 1 to 12 fail on month first.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] v;
      case (m)
         4'd2:                       v = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    v = 5'd30;
         default:                    v = 5'd31;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dvdn_day_calc.sv
// Three-stage pipeline that checks one date and forms its day number.
`default_nettype none

module dvdn_day_calc (
   input  wire logic                          clock,
   input  wire dvdn_pkg::date_type            date,
   input  wire logic [dvdn_pkg::YEAR_W-1:0]   year_floor,
   input  wire logic [dvdn_pkg::YEAR_W-1:0]   current_year,
   output dvdn_pkg::date_result_type          result
);

   // Stage 1: shifted year and month, reciprocal products, range checks.
   logic                                  early;
   logic signed [dvdn_pkg::YEAR_W:0]      ty;
   logic [dvdn_pkg::YEAR_W-1:0]           tyu;
   logic [dvdn_pkg::MONTH_W-1:0]          tm;

   logic [dvdn_pkg::PROD_W-1:0]           prod_y_in, prod_y_ff;
   logic [dvdn_pkg::PROD_W-1:0]           prod_t_in, prod_t_ff;
   logic [dvdn_pkg::NUM_W-1:0]            m365_in, m365_ff;
   logic [dvdn_pkg::YEAR_W-3:0]           tyq4_in, tyq4_ff;
   logic [dvdn_pkg::MTERM_W-1:0]          mterm_in, mterm_ff;
   logic                                  year_bad_in, year_bad_ff;
   logic                                  month_bad_in, month_bad_ff;
   dvdn_pkg::date_type                    date_ff;

   always_comb begin
      early    = date.month < dvdn_pkg::MONTH_W'(dvdn_pkg::MARCH);
      ty       = $signed({1'b0, date.year}) - (early ? 15'sd1 : 15'sd0);
      tyu      = ty[dvdn_pkg::YEAR_W] ? '0 : ty[dvdn_pkg::YEAR_W-1:0];
      tm       = early ? date.month + dvdn_pkg::MONTH_W'(dvdn_pkg::MONTHS) : date.month;
      prod_y_in = dvdn_pkg::PROD_W'(date.year[dvdn_pkg::YEAR_W-1:2])
                  * dvdn_pkg::PROD_W'(dvdn_pkg::RECIP_100);
      prod_t_in = dvdn_pkg::PROD_W'(tyu[dvdn_pkg::YEAR_W-1:2])
                  * dvdn_pkg::PROD_W'(dvdn_pkg::RECIP_100);
      m365_in  = dvdn_pkg::NUM_W'(ty) * dvdn_pkg::NUM_W'(dvdn_pkg::DAYS_PER_YEAR);
      tyq4_in  = tyu[dvdn_pkg::YEAR_W-1:2];
      mterm_in = dvdn_pkg::month_term(tm);
      year_bad_in  = (date.year < year_floor)
                     || ({1'b0, date.year} > ({1'b0, current_year} + 15'd1));
      month_bad_in = (date.month == '0)
                     || (date.month > dvdn_pkg::MONTH_W'(dvdn_pkg::MONTHS));
   end

   always_ff @(posedge clock) begin
      prod_y_ff    <= prod_y_in;
      prod_t_ff    <= prod_t_in;
      m365_ff      <= m365_in;
      tyq4_ff      <= tyq4_in;
      mterm_ff     <= mterm_in;
      year_bad_ff  <= year_bad_in;
      month_bad_ff <= month_bad_in;
      date_ff      <= date;
   end

   // Stage 2: quotients by 100, leap year, day check and two partial sums.
   logic [dvdn_pkg::Q_W-1:0]              qy;
   logic [dvdn_pkg::Q_W-1:0]              qt;
   logic                                  cent;
   logic                                  leap;
   logic [dvdn_pkg::DAY_W-1:0]            len;
   logic                                  day_bad;
   logic [dvdn_pkg::NUM_W-1:0]            part_a_in, part_a_ff;
   logic [dvdn_pkg::PB_W-1:0]             part_b_in, part_b_ff;
   dvdn_pkg::status_type                  status_in, status2_ff;

   always_comb begin
      qy   = prod_y_ff[dvdn_pkg::RECIP_SHIFT +: dvdn_pkg::Q_W];
      qt   = prod_t_ff[dvdn_pkg::RECIP_SHIFT +: dvdn_pkg::Q_W];
      cent = date_ff.year
             == dvdn_pkg::YEAR_W'(qy * dvdn_pkg::YEAR_W'(dvdn_pkg::CENTURY));
      leap = ((date_ff.year[1:0] == 2'd0) && !cent) || (cent && (qy[1:0] == 2'd0));
      len  = dvdn_pkg::month_length(date_ff.month)
             + dvdn_pkg::DAY_W'(leap
                && (date_ff.month == dvdn_pkg::MONTH_W'(dvdn_pkg::FEBRUARY)));
      day_bad = (date_ff.day == '0) || (date_ff.day > len);

      if (year_bad_ff) begin
         status_in = dvdn_pkg::STATUS_YEAR_BAD;
      end else if (month_bad_ff) begin
         status_in = dvdn_pkg::STATUS_MONTH_BAD;
      end else if (day_bad) begin
         status_in = dvdn_pkg::STATUS_DAY_BAD;
      end else begin
         status_in = dvdn_pkg::STATUS_OK;
      end

      part_a_in = m365_ff + dvdn_pkg::NUM_W'(tyq4_ff);
      part_b_in = dvdn_pkg::PB_W'(mterm_ff) + dvdn_pkg::PB_W'(date_ff.day)
                  + dvdn_pkg::PB_W'(qt[dvdn_pkg::Q_W-1:2]) - dvdn_pkg::PB_W'(qt)
                  - dvdn_pkg::PB_W'(dvdn_pkg::DAY_OFFSET);
   end

   always_ff @(posedge clock) begin
      part_a_ff  <= part_a_in;
      part_b_ff  <= part_b_in;
      status2_ff <= status_in;
   end

   // Stage 3: final day number.
   dvdn_pkg::date_result_type             result_in, result_ff;

   always_comb begin
      result_in.status = status2_ff;
      result_in.days   = $signed(part_a_ff)
                         + dvdn_pkg::NUM_W'($signed(part_b_ff));
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

FILE: rtl/date_validate_and_day_number.sv
// Top level: checks two Gregorian dates and gives day numbers, difference and order.
// A beat accepted at a clock edge runs through four register stages, the last being the
// output stage, before it shows on the rsp_ ports.
// Throughput: one beat per cycle; busy never rises, since every stage advances each cycle.
// Reset (synchronous, active high) clears the stage valid bits and the strobe, and sets
// the year floor to 1 and current_year to 2023.
`default_nettype none

module date_validate_and_day_number (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [dvdn_pkg::YEAR_W-1:0]          req_year_a,
   input  wire logic [dvdn_pkg::MONTH_W-1:0]         req_month_a,
   input  wire logic [dvdn_pkg::DAY_W-1:0]           req_day_a,
   input  wire logic [dvdn_pkg::YEAR_W-1:0]          req_year_b,
   input  wire logic [dvdn_pkg::MONTH_W-1:0]         req_month_b,
   input  wire logic [dvdn_pkg::DAY_W-1:0]           req_day_b,

   output logic                                      rsp_valid,
   output logic [1:0]                                rsp_status_a,
   output logic [1:0]                                rsp_status_b,
   output logic signed [dvdn_pkg::FIELD_W-1:0]       rsp_days_a,
   output logic signed [dvdn_pkg::FIELD_W-1:0]       rsp_days_b,
   output logic signed [dvdn_pkg::FIELD_W-1:0]       rsp_difference,
   output logic [1:0]                                rsp_order,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dvdn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [dvdn_pkg::YEAR_W-1:0]          csr_data
);

   // The pipeline never stalls, so a new beat is taken in every cycle and a register
   // write completes in the cycle it is offered.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers. Writes to an index beyond the list are dropped.
   logic [dvdn_pkg::YEAR_W-1:0] year_floor_ff, year_floor_in;
   logic [dvdn_pkg::YEAR_W-1:0] current_year_ff, current_year_in;

   always_comb begin
      year_floor_in   = year_floor_ff;
      current_year_in = current_year_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dvdn_pkg::CSR_YEAR_FLOOR:   year_floor_in   = csr_data;
            dvdn_pkg::CSR_CURRENT_YEAR: current_year_in = csr_data;
            default:                    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_floor_ff   <= dvdn_pkg::YEAR_W'(dvdn_pkg::RESET_YEAR_FLOOR);
         current_year_ff <= dvdn_pkg::YEAR_W'(dvdn_pkg::RESET_CURRENT_YEAR);
      end else begin
         year_floor_ff   <= year_floor_in;
         current_year_ff <= current_year_in;
      end
   end

   // Valid bits travel beside the three stages of the date pipelines and the output stage.
   logic accept;
   logic [2:0] stage_valid_ff, stage_valid_in;
   logic rsp_valid_ff;

   assign accept         = start && !busy;
   assign stage_valid_in = {stage_valid_ff[1:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= stage_valid_ff[2];
      end
   end

   // Both dates run through identical pipelines side by side.
   dvdn_pkg::date_type        date_a, date_b;
   dvdn_pkg::date_result_type res_a, res_b;

   assign date_a = '{year: req_year_a, month: req_month_a, day: req_day_a};
   assign date_b = '{year: req_year_b, month: req_month_b, day: req_day_b};

   dvdn_day_calc u_calc_a (
      .clock        (clock),
      .date         (date_a),
      .year_floor   (year_floor_ff),
      .current_year (current_year_ff),
      .result       (res_a)
   );

   dvdn_day_calc u_calc_b (
      .clock        (clock),
      .date         (date_b),
      .year_floor   (year_floor_ff),
      .current_year (current_year_ff),
      .result       (res_b)
   );

   // Output stage: the difference and order are decided on the full-width day numbers,
   // and only then are the numbers cut to the field width.
   logic signed [dvdn_pkg::DIFF_W-1:0] diff;
   dvdn_pkg::order_type                order_in;

   logic [1:0]                         status_a_ff, status_b_ff;
   logic signed [dvdn_pkg::FIELD_W-1:0] days_a_ff, days_b_ff, difference_ff;
   logic [1:0]                         order_ff;

   always_comb begin
      diff = dvdn_pkg::DIFF_W'(res_a.days) - dvdn_pkg::DIFF_W'(res_b.days);
      if (res_a.days < res_b.days) begin
         order_in = dvdn_pkg::ORDER_BEFORE;
      end else if (res_a.days == res_b.days) begin
         order_in = dvdn_pkg::ORDER_EQUAL;
      end else begin
         order_in = dvdn_pkg::ORDER_AFTER;
      end
   end

   always_ff @(posedge clock) begin
      status_a_ff   <= res_a.status;
      status_b_ff   <= res_b.status;
      days_a_ff     <= res_a.days[dvdn_pkg::FIELD_W-1:0];
      days_b_ff     <= res_b.days[dvdn_pkg::FIELD_W-1:0];
      difference_ff <= diff[dvdn_pkg::FIELD_W-1:0];
      order_ff      <= order_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status_a   = status_a_ff;
   assign rsp_status_b   = status_b_ff;
   assign rsp_days_a     = days_a_ff;
   assign rsp_days_b     = days_b_ff;
   assign rsp_difference = difference_ff;
   assign rsp_order      = order_ff;

endmodule

`default_nettype wire

FILE: rtl/dvdn_checker.sv
// Port-level checker for the date block and the bind that attaches it.
`default_nettype none
`include "assert_macros.svh"

module dvdn_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 start,
   input wire logic                                 busy,
   input wire logic                                 rsp_valid,
   input wire logic signed [dvdn_pkg::FIELD_W-1:0]  rsp_days_a,
   input wire logic signed [dvdn_pkg::FIELD_W-1:0]  rsp_days_b,
   input wire logic signed [dvdn_pkg::FIELD_W-1:0]  rsp_difference,
   input wire logic [1:0]                           rsp_order
);

   logic       accepted;
   logic       order_equal;
   logic       order_unequal;
   logic [2:0] reset_hist_ff;

   assign accepted      = start && !busy && !reset;
   assign order_equal   = rsp_valid && (rsp_order == dvdn_pkg::ORDER_EQUAL);
   assign order_unequal = rsp_valid && (rsp_order != dvdn_pkg::ORDER_EQUAL);

   // History of reset samples, newest in bit 0.
   always_ff @(posedge clock) begin
      reset_hist_ff <= {reset_hist_ff[1:0], reset};
   end

   // A result beat always comes from an earlier beat accepted outside reset.
   `ASSERT_IMPL(a_rsp_has_req, rsp_valid, $past(accepted, 4))

   // An accepted beat with no reset since then always produces its result beat.
   `ASSERT_IMPL(a_req_gives_rsp, $past(accepted, 4) && (reset_hist_ff == 3'b000), rsp_valid)

   // Equal order means equal day numbers and a zero difference.
   `ASSERT_IMPL(a_equal_zero, order_equal, (rsp_difference == '0) && (rsp_days_a == rsp_days_b))

   // Unequal order never shows a zero difference.
   `ASSERT_IMPL(a_unequal_nonzero, order_unequal, rsp_difference != '0)

endmodule

bind date_validate_and_day_number dvdn_checker u_dvdn_checker (.*);

`default_nettype wire

FILE: sim/date_pair_checker_pkg.sv
// Scoreboard class that predicts and checks date status, day numbers, difference and order.
`timescale 1ns / 1ps

package date_pair_checker_pkg;
   import dvdn_pkg::*;

   typedef struct packed {
      status_type                status_a;
      status_type                status_b;
      logic signed [FIELD_W-1:0] days_a;
      logic signed [FIELD_W-1:0] days_b;
      logic signed [FIELD_W-1:0] difference;
      order_type                 order;
   } date_pair_result_type;

   class date_pair_checker;
      int unsigned          year_floor;
      int unsigned          current_year;
      int unsigned          errors;
      date_pair_result_type awaited_results[$];

      function new();
         year_floor   = RESET_YEAR_FLOOR;
         current_year = RESET_CURRENT_YEAR;
         errors       = 0;
      endfunction

      function int unsigned outstanding();
         return awaited_results.size();
      endfunction

      // Indexes other than the two limit registers are dropped by the block.
      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [YEAR_W-1:0] data);
         if (idx == CSR_YEAR_FLOOR) begin
            year_floor = int'(data);
         end else if (idx == CSR_CURRENT_YEAR) begin
            current_year = int'(data);
         end
      endfunction

      function bit leap_year(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      function int unsigned days_in_month(int unsigned m, int unsigned y);
         case (m)
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
         endcase
      endfunction

      // Checks run year first, then month, then day; the first failure wins.
      function status_type date_status(date_type d);
         if (d.year < year_floor || d.year > current_year + 1) return STATUS_YEAR_BAD;
         if (d.month < 1 || d.month > 12) return STATUS_MONTH_BAD;
         if (d.day < 1 || d.day > days_in_month(d.month, d.year)) return STATUS_DAY_BAD;
         return STATUS_OK;
      endfunction

      // March-based count; January and February belong to the year before.
      // Signed int division truncates toward zero, as the block does.
      function int day_count(date_type d);
         int y;
         int m;
         y = int'(d.year);
         m = int'(d.month);
         if (m < 3) begin
            y = y - 1;
            m = m + 12;
         end
         return 365 * y + y / 4 - y / 100 + y / 400 + (153 * m - 457) / 5 + int'(d.day) - 306;
      endfunction

      function date_pair_result_type predict_pair(date_type a, date_type b);
         date_pair_result_type r;
         int                   na;
         int                   nb;
         int                   diff;
         na           = day_count(a);
         nb           = day_count(b);
         diff         = na - nb;
         r.status_a   = date_status(a);
         r.status_b   = date_status(b);
         r.days_a     = na[FIELD_W-1:0];
         r.days_b     = nb[FIELD_W-1:0];
         r.difference = diff[FIELD_W-1:0];
         r.order      = (na < nb) ? ORDER_BEFORE : ((na == nb) ? ORDER_EQUAL : ORDER_AFTER);
         return r;
      endfunction

      function void note_request(date_type a, date_type b);
         awaited_results.push_back(predict_pair(a, b));
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_field(string name, int got, int want);
         if (got != want) begin
            report($sformatf("%s got %0d expected %0d", name, got, want));
         end
      endtask

      task check_response(logic [1:0] status_a, logic [1:0] status_b,
                          logic signed [FIELD_W-1:0] days_a,
                          logic signed [FIELD_W-1:0] days_b,
                          logic signed [FIELD_W-1:0] difference,
                          logic [1:0] order);
         date_pair_result_type want;
         if (awaited_results.size() == 0) begin
            report("result beat with no request outstanding");
         end else begin
            want = awaited_results.pop_front();
            check_field("status_a", int'(status_a), int'(want.status_a));
            check_field("status_b", int'(status_b), int'(want.status_b));
            check_field("days_a", int'(days_a), int'(want.days_a));
            check_field("days_b", int'(days_b), int'(want.days_b));
            check_field("difference", int'(difference), int'(want.difference));
            check_field("order", int'(order), int'(want.order));
         end
      endtask
   endclass

endpackage

FILE: sim/tb_top.sv
// Testbench top level for the date check and day number block.
`timescale 1ns / 1ps

module tb_top;
   import dvdn_pkg::*;
   import date_pair_checker_pkg::*;

   // Pause after the last awaited result, giving the pipeline some margin to settle.
   localparam int SETTLE_CYCLES  = 8;
   // Cycles without any handshake on any channel before the run is declared hung.
   localparam int STALL_LIMIT    = 2000;
   localparam int ITEMS_PER_PASS = 220;
   localparam int MAX_YEAR       = (1 << YEAR_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       start       = 1'b0;
   logic                       busy;
   logic [YEAR_W-1:0]          req_year_a  = '0;
   logic [MONTH_W-1:0]         req_month_a = '0;
   logic [DAY_W-1:0]           req_day_a   = '0;
   logic [YEAR_W-1:0]          req_year_b  = '0;
   logic [MONTH_W-1:0]         req_month_b = '0;
   logic [DAY_W-1:0]           req_day_b   = '0;

   logic                       rsp_valid;
   logic [1:0]                 rsp_status_a;
   logic [1:0]                 rsp_status_b;
   logic signed [FIELD_W-1:0]  rsp_days_a;
   logic signed [FIELD_W-1:0]  rsp_days_b;
   logic signed [FIELD_W-1:0]  rsp_difference;
   logic [1:0]                 rsp_order;

   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index   = '0;
   logic [YEAR_W-1:0]          csr_data    = '0;

   date_pair_checker dates = new();
   int unsigned      quiet_cycles = 0;

   always #5 clock = ~clock;

   date_validate_and_day_number uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_year_a     (req_year_a),
      .req_month_a    (req_month_a),
      .req_day_a      (req_day_a),
      .req_year_b     (req_year_b),
      .req_month_b    (req_month_b),
      .req_day_b      (req_day_b),
      .rsp_valid      (rsp_valid),
      .rsp_status_a   (rsp_status_a),
      .rsp_status_b   (rsp_status_b),
      .rsp_days_a     (rsp_days_a),
      .rsp_days_b     (rsp_days_b),
      .rsp_difference (rsp_difference),
      .rsp_order      (rsp_order),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // Result beats are taken at the edge that closes their cycle. Reading the ports in the
   // active region of that edge sees the values from before the block's own updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         dates.check_response(rsp_status_a, rsp_status_b, rsp_days_a, rsp_days_b,
                              rsp_difference, rsp_order);
      end
   end

   // The watchdog restarts whenever a beat moves on any channel. Only pauses that the
   // testbench itself makes, which are short, or a hung block can let it run out.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic date_type make_date(int unsigned y, int unsigned m, int unsigned d);
      date_type t;
      t.year  = YEAR_W'(y);
      t.month = MONTH_W'(m);
      t.day   = DAY_W'(d);
      return t;
   endfunction

   // Offers one date pair and holds it until the block takes it. The scoreboard is told
   // at the accepting edge, so it always runs ahead of the matching result beat.
   task automatic send_dates(input date_type a, input date_type b);
      start       <= 1'b1;
      req_year_a  <= a.year;
      req_month_a <= a.month;
      req_day_a   <= a.day;
      req_year_b  <= b.year;
      req_month_b <= b.month;
      req_day_b   <= b.day;
      do @(posedge clock); while (busy);
      dates.note_request(a, b);
   endtask

   // Drops start for a number of cycles and puts junk on the request fields meanwhile,
   // since the block must ignore them while start is low.
   task automatic hold_off(input int unsigned cycles);
      if (cycles > 0) begin
         start       <= 1'b0;
         req_year_a  <= YEAR_W'($urandom);
         req_month_a <= MONTH_W'($urandom);
         req_day_a   <= DAY_W'($urandom);
         req_year_b  <= YEAR_W'($urandom);
         req_month_b <= MONTH_W'($urandom);
         req_day_b   <= DAY_W'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Each idle cycle is taken with the given chance in percent, capped so that the gap
   // stays well clear of the watchdog.
   function automatic int unsigned idle_gap(input int unsigned percent);
      int unsigned n;
      n = 0;
      while (n < 20 && $urandom_range(99) < percent) n++;
      return n;
   endfunction

   // Stops offering beats until every outstanding result has arrived, then lets the
   // pipeline settle. Limit registers are only written after this.
   task automatic drain();
      start <= 1'b0;
      while (dates.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both limit registers and one unused index, which the block must drop.
   // The valid is lowered only once, after the last write beat.
   task automatic apply_limits(input int unsigned year_floor, input int unsigned current_year);
      logic [CSR_IDX_W-1:0] idx[3];
      logic [YEAR_W-1:0]    val[3];
      idx[0] = CSR_YEAR_FLOOR;
      val[0] = YEAR_W'(year_floor);
      idx[1] = CSR_IDX_W'($urandom_range((1 << CSR_IDX_W) - 1, CSR_CURRENT_YEAR + 1));
      val[1] = YEAR_W'($urandom);
      idx[2] = CSR_CURRENT_YEAR;
      val[2] = YEAR_W'(current_year);
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         dates.set_register(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Most dates are well formed and sit inside the accepted years, so the day check is
   // reached; the rest sit on the year limits or are plain noise over the full fields.
   function automatic date_type random_date(input int unsigned lo, input int unsigned hi);
      date_type    t;
      int unsigned pick;
      int unsigned top;
      pick = $urandom_range(99);
      top  = (hi > MAX_YEAR) ? MAX_YEAR : hi;
      if (lo > top) top = lo;
      if (pick < 15) begin
         t = make_date($urandom_range(MAX_YEAR), $urandom_range(15), $urandom_range(31));
      end else begin
         if (pick < 30) begin
            case ($urandom_range(3))
               0:       t.year = YEAR_W'((lo > 0) ? lo - 1 : lo);
               1:       t.year = YEAR_W'(lo);
               2:       t.year = YEAR_W'(top);
               default: t.year = YEAR_W'((top < MAX_YEAR) ? top + 1 : top);
            endcase
         end else begin
            t.year = YEAR_W'($urandom_range(top, lo));
         end
         t.month = MONTH_W'(($urandom_range(99) < 92) ? $urandom_range(12, 1)
                                                       : $urandom_range(15));
         pick = $urandom_range(99);
         if (pick < 80) t.day = DAY_W'($urandom_range(28, 1));
         else if (pick < 96) t.day = DAY_W'($urandom_range(31, 29));
         else t.day = '0;
      end
      return t;
   endfunction

   // One pass of random pairs under fixed limits. The second date is sometimes the first
   // one again or a day away from it, so that equal and close orders come up often.
   task automatic random_pass(input int unsigned year_floor, input int unsigned current_year,
                              input int unsigned idle_percent);
      date_type a;
      date_type b;
      int unsigned pick;
      for (int i = 0; i < ITEMS_PER_PASS; i++) begin
         a    = random_date(year_floor, current_year + 1);
         pick = $urandom_range(99);
         if (pick < 10) begin
            b = a;
         end else if (pick < 20) begin
            b     = a;
            b.day = a.day + (($urandom_range(1) == 0) ? 5'd1 : 5'h1f);
         end else begin
            b = random_date(year_floor, current_year + 1);
         end
         send_dates(a, b);
         hold_off(idle_gap(idle_percent));
      end
   endtask

   initial begin
      int unsigned lows[9];
      int unsigned highs[9];
      int unsigned idle_percent;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs under the reset limits, years 1 to 2024.
      // Field extremes on both sides: both dates fail on the year.
      send_dates(make_date(0, 0, 0), make_date(MAX_YEAR, 15, 31));
      send_dates(make_date(MAX_YEAR, 15, 31), make_date(0, 0, 0));
      // The first day of the count, against itself.
      send_dates(make_date(1, 1, 1), make_date(1, 1, 1));
      // A century year divisible by 400 keeps the leap day; one that is not loses it.
      send_dates(make_date(2000, 2, 29), make_date(1900, 2, 29));
      // The year after the current one is still accepted; the one after that is not.
      send_dates(make_date(2024, 2, 29), make_date(2025, 1, 1));
      send_dates(make_date(2023, 2, 29), make_date(2020, 2, 29));
      // Months outside 1 to 12, including month zero which counts as December before.
      send_dates(make_date(2023, 13, 1), make_date(2023, 0, 15));
      // A bad year hides a bad month; April has no 31st.
      send_dates(make_date(3000, 13, 31), make_date(2023, 4, 31));
      send_dates(make_date(2023, 12, 31), make_date(2023, 1, 0));
      send_dates(make_date(2023, 11, 30), make_date(2023, 11, 31));
      // Year zero with January or February steps back to year minus one and goes negative.
      send_dates(make_date(0, 1, 1), make_date(0, 2, 28));
      send_dates(make_date(0, 3, 1), make_date(1, 14, 5));
      // Plain ordering, both ways, and the years 9999 and 1 against each other.
      send_dates(make_date(2023, 6, 15), make_date(2023, 6, 16));
      send_dates(make_date(2023, 6, 16), make_date(2023, 6, 15));
      send_dates(make_date(9999, 12, 31), make_date(1, 1, 1));
      // Years as large as these make the 23-bit day numbers wrap.
      send_dates(make_date(12000, 15, 31), make_date(MAX_YEAR, 1, 1));
      drain();

      // Widest limits: year zero is valid, and so is every year the field can carry.
      apply_limits(0, MAX_YEAR);
      send_dates(make_date(0, 2, 29), make_date(0, 3, 1));
      send_dates(make_date(MAX_YEAR, 12, 31), make_date(MAX_YEAR, 2, 29));
      drain();

      // Narrowest limits at the top: only the largest year is valid.
      apply_limits(MAX_YEAR, MAX_YEAR);
      send_dates(make_date(MAX_YEAR, 5, 5), make_date(MAX_YEAR - 1, 5, 5));
      send_dates(make_date(0, 1, 1), make_date(MAX_YEAR, 0, 0));
      drain();

      // Random passes, each under its own limits and followed by a full drain before the
      // next write. Sender idling is 30 percent in the first third, then 68, then none.
      lows  = '{RESET_YEAR_FLOOR, 0, MAX_YEAR, 1, 0, 9999, 0, 0, 1900};
      highs = '{RESET_CURRENT_YEAR, MAX_YEAR, MAX_YEAR, 1, 0, 9998, 0, 0, 2100};
      lows[6]  = $urandom_range(9999, 1);
      highs[6] = $urandom_range(9998, (lows[6] > 1) ? lows[6] - 1 : 1);
      lows[7]  = $urandom_range(MAX_YEAR);
      highs[7] = $urandom_range(MAX_YEAR);
      for (int p = 0; p < 9; p++) begin
         apply_limits(lows[p], highs[p]);
         idle_percent = (p < 3) ? 30 : ((p < 6) ? 68 : 0);
         random_pass(lows[p], highs[p], idle_percent);
         drain();
      end

      if (dates.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
